### rtl/hia_pkg.sv
`timescale 1ns / 1ps
package hia_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int HANDLE_W       = 16;
  localparam int DATA_W         = 32;
  localparam int SLOTS_CFG_W    = 9;
  localparam int CFG_DATA_W     = 16;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_REBUILD = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_BASE_HANDLE  = 1'b0,
    CFG_SLOTS_IN_USE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic live;
    logic linked;
  } link_flag_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    logic [DATA_W-1:0]   result_value;
    logic                ok;
    logic [DATA_W-1:0]   free_left;
  } result_t;

endpackage

### rtl/hia_if.sv
`timescale 1ns / 1ps
interface hia_in_if;
  logic                     valid;
  logic                     ready;
  hia_pkg::cmd_t            command;
  logic [15:0]              item_handle;
  logic [31:0]              item_value;

  modport source (output valid, command, item_handle, item_value, input ready);
  modport sink   (input valid, command, item_handle, item_value, output ready);
endinterface

interface hia_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        result_handle;
  logic [31:0]        result_value;
  logic               ok;
  logic signed [31:0] free_left;

  modport source (output valid, result_handle, result_value, ok, free_left, input ready);
  modport sink   (input valid, result_handle, result_value, ok, free_left, output ready);
endinterface

### rtl/hia_store.sv
`timescale 1ns / 1ps
module hia_store #(
  parameter int SLOTS      = hia_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = hia_pkg::VALUE_BITS_DEF,
  parameter int IW         = $clog2(SLOTS),
  parameter int LW         = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  // value store
  input  logic                   val_we,
  input  logic [IW-1:0]          val_waddr,
  input  logic [VALUE_BITS-1:0]  val_wdata,
  input  logic [IW-1:0]          val_raddr,
  output logic [VALUE_BITS-1:0]  val_rdata,
  // link stores, one read address shared
  input  logic                   nxt_we,
  input  logic [IW-1:0]          nxt_waddr,
  input  logic [LW-1:0]          nxt_wdata,
  input  logic                   prv_we,
  input  logic [IW-1:0]          prv_waddr,
  input  logic [LW-1:0]          prv_wdata,
  input  logic                   flg_we,
  input  logic [IW-1:0]          flg_waddr,
  input  hia_pkg::link_flag_t    flg_wdata,
  input  logic [IW-1:0]          lnk_raddr,
  output logic [LW-1:0]          nxt_rdata,
  output logic [LW-1:0]          prv_rdata,
  output hia_pkg::link_flag_t    flg_rdata
);
  import hia_pkg::*;

  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [LW-1:0]         nxt_mem [SLOTS];
  logic [LW-1:0]         prv_mem [SLOTS];
  link_flag_t            flg_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rdata <= val_mem[val_raddr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    nxt_rdata <= nxt_mem[lnk_raddr];
  end

  always_ff @(posedge clk) begin
    if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
    prv_rdata <= prv_mem[lnk_raddr];
  end

  always_ff @(posedge clk) begin
    if (flg_we) flg_mem[flg_waddr] <= flg_wdata;
    flg_rdata <= flg_mem[lnk_raddr];
  end

endmodule

### rtl/hia_ctrl.sv
`timescale 1ns / 1ps
module hia_ctrl #(
  parameter int SLOTS      = hia_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = hia_pkg::VALUE_BITS_DEF,
  parameter int IW         = $clog2(SLOTS),
  parameter int LW         = $clog2(SLOTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hia_pkg::cmd_t          in_command,
  input  logic [15:0]            in_handle,
  input  logic [31:0]            in_value,
  input  logic [15:0]            base_handle,
  input  logic [8:0]             slots_in_use,
  output logic                   res_valid,
  input  logic                   res_ready,
  output hia_pkg::result_t       res,
  output logic                   val_we,
  output logic [IW-1:0]          val_waddr,
  output logic [VALUE_BITS-1:0]  val_wdata,
  output logic [IW-1:0]          val_raddr,
  input  logic [VALUE_BITS-1:0]  val_rdata,
  output logic                   nxt_we,
  output logic [IW-1:0]          nxt_waddr,
  output logic [LW-1:0]          nxt_wdata,
  output logic                   prv_we,
  output logic [IW-1:0]          prv_waddr,
  output logic [LW-1:0]          prv_wdata,
  output logic                   flg_we,
  output logic [IW-1:0]          flg_waddr,
  output hia_pkg::link_flag_t    flg_wdata,
  output logic [IW-1:0]          lnk_raddr,
  input  logic [LW-1:0]          nxt_rdata,
  input  logic [LW-1:0]          prv_rdata,
  input  hia_pkg::link_flag_t    flg_rdata
);
  import hia_pkg::*;

  localparam logic [LW-1:0] NONE    = LW'(SLOTS);
  localparam int            RST_CNT = (SLOTS < 256) ? SLOTS : 256;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOOK  = 11'b00000000100,
    S_PICK  = 11'b00000001000,
    S_LRD   = 11'b00000010000,
    S_UNL   = 11'b00000100000,
    S_PUSH  = 11'b00001000000,
    S_PUSH2 = 11'b00010000000,
    S_SWRD  = 11'b00100000000,
    S_SWCK  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [15:0]           hdl_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IW-1:0]         idx_r;
  logic                  tgt_live_r;
  logic                  in_sweep_r;
  logic                  reply_r;
  logic [LW-1:0]         swp_i_r;
  logic [LW-1:0]         rb_i_r;
  logic [LW-1:0]         count_r;
  logic [15:0]           rb_base_r;
  logic [LW-1:0]         fhead_r, ftail_r, lhead_r, ltail_r;
  logic [31:0]           total_r;
  logic [15:0]           rhdl_r;
  logic [31:0]           rval_r;
  logic                  ok_r;

  logic                  acc;
  logic                  hit_in, hit_r;
  logic [IW-1:0]         midx_in, midx_r;
  logic                  pick_any, pick_good;
  logic [IW-1:0]         pick_idx;
  logic [15:0]           pick_id;
  logic                  sw_hit;
  logic [IW-1:0]         sw_idx;
  logic [LW-1:0]         hsel;
  logic                  rb_in;
  logic [LW-1:0]         c_new;
  logic [63:0]           rd_wide;

  function automatic logic map_hit(input logic [15:0] h, input logic [15:0] b,
                                   input logic [LW-1:0] c);
    logic [15:0] d;
    d = h - b;
    return (h >= b) && (32'(d) < 32'(c));
  endfunction

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign hit_in    = map_hit(in_handle, base_handle, count_r);
  assign midx_in   = IW'(in_handle - base_handle);
  assign hit_r     = map_hit(hdl_r, base_handle, count_r);
  assign midx_r    = IW'(hdl_r - base_handle);
  assign pick_any  = (hdl_r == 16'd0);
  assign pick_good = pick_any ? (ftail_r != NONE) : hit_r;
  assign pick_idx  = pick_any ? IW'(ftail_r) : midx_r;
  assign pick_id   = !pick_any ? hdl_r :
                     (ftail_r == '0) ? 16'd0 : 16'(32'(rb_base_r) + 32'(ftail_r));
  assign sw_hit    = (val_rdata == '0) && (32'(swp_i_r) >= 32'(base_handle));
  assign sw_idx    = IW'(32'(swp_i_r) - 32'(base_handle));
  assign hsel      = tgt_live_r ? lhead_r : fhead_r;
  assign rb_in     = (rb_i_r != '0) && (rb_i_r < count_r);
  assign c_new     = (32'(slots_in_use) > 32'(SLOTS)) ? LW'(SLOTS) : LW'(slots_in_use);
  assign rd_wide   = 64'(val_rdata);

  assign res_valid = (state_r == S_DONE);
  assign res       = '{result_handle: rhdl_r, result_value: rval_r, ok: ok_r,
                       free_left: total_r};

  // memory ports
  always_comb begin
    val_we    = 1'b0;
    val_waddr = idx_r;
    val_wdata = '0;
    val_raddr = midx_in;
    nxt_we    = 1'b0;
    nxt_waddr = idx_r;
    nxt_wdata = NONE;
    prv_we    = 1'b0;
    prv_waddr = idx_r;
    prv_wdata = NONE;
    flg_we    = 1'b0;
    flg_waddr = idx_r;
    flg_wdata = '{live: 1'b0, linked: 1'b0};
    lnk_raddr = idx_r;
    case (state_r)
      S_CLEAR: begin
        val_we    = 1'b1;
        val_waddr = IW'(rb_i_r);
        nxt_we    = 1'b1;
        nxt_waddr = IW'(rb_i_r);
        nxt_wdata = (rb_in && rb_i_r != LW'(1)) ? rb_i_r - LW'(1) : NONE;
        prv_we    = 1'b1;
        prv_waddr = IW'(rb_i_r);
        prv_wdata = (rb_in && (rb_i_r + LW'(1)) < count_r) ? rb_i_r + LW'(1) : NONE;
        flg_we    = 1'b1;
        flg_waddr = IW'(rb_i_r);
        flg_wdata = '{live: 1'b0, linked: rb_in};
      end
      S_IDLE: begin
        val_we    = acc && (in_command == CMD_RELEASE) && hit_in;
        val_waddr = midx_in;
      end
      S_PICK: begin
        val_we    = pick_good;
        val_waddr = pick_idx;
        val_wdata = val_r;
      end
      S_UNL: begin
        nxt_we    = flg_rdata.linked && (prv_rdata != NONE);
        nxt_waddr = IW'(prv_rdata);
        nxt_wdata = nxt_rdata;
        prv_we    = flg_rdata.linked && (nxt_rdata != NONE);
        prv_waddr = IW'(nxt_rdata);
        prv_wdata = prv_rdata;
      end
      S_PUSH: begin
        nxt_we    = 1'b1;
        nxt_wdata = hsel;
        flg_we    = 1'b1;
        flg_wdata = '{live: tgt_live_r, linked: 1'b1};
        prv_we    = (hsel != NONE);
        prv_waddr = IW'(hsel);
        prv_wdata = LW'(idx_r);
      end
      S_PUSH2: prv_we = 1'b1;
      S_SWRD:  val_raddr = IW'(swp_i_r);
      S_SWCK: begin
        val_we    = sw_hit;
        val_waddr = sw_idx;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (rb_i_r == LW'(SLOTS - 1)) state_nxt = reply_r ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (acc) begin
          case (in_command)
            CMD_ALLOC:   state_nxt = (total_r == '0 && count_r >= LW'(2)) ? S_SWRD : S_PICK;
            CMD_RELEASE: state_nxt = hit_in ? S_LRD : S_DONE;
            CMD_LOOKUP:  state_nxt = hit_in ? S_LOOK : S_DONE;
            default:     state_nxt = S_CLEAR;
          endcase
        end
      end
      S_LOOK:  state_nxt = S_DONE;
      S_PICK:  state_nxt = pick_good ? S_LRD : S_DONE;
      S_LRD:   state_nxt = S_UNL;
      S_UNL:   state_nxt = S_PUSH;
      S_PUSH:  state_nxt = S_PUSH2;
      S_PUSH2: state_nxt = !in_sweep_r ? S_DONE :
                           (swp_i_r == LW'(1)) ? S_PICK : S_SWRD;
      S_SWRD:  state_nxt = S_SWCK;
      S_SWCK:  state_nxt = sw_hit ? S_LRD : (swp_i_r == LW'(1)) ? S_PICK : S_SWRD;
      S_DONE:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      reply_r    <= 1'b0;
      rb_i_r     <= '0;
      count_r    <= LW'(RST_CNT);
      rb_base_r  <= '0;
      fhead_r    <= (RST_CNT >= 2) ? LW'(RST_CNT - 1) : NONE;
      ftail_r    <= (RST_CNT >= 2) ? LW'(1) : NONE;
      lhead_r    <= NONE;
      ltail_r    <= NONE;
      total_r    <= (RST_CNT >= 2) ? 32'(RST_CNT - 1) : 32'd0;
      in_sweep_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: rb_i_r <= rb_i_r + LW'(1);
        S_IDLE: begin
          if (acc) begin
            hdl_r      <= in_handle;
            val_r      <= VALUE_BITS'(in_value);
            rhdl_r     <= in_handle;
            rval_r     <= '0;
            ok_r       <= hit_in;
            in_sweep_r <= 1'b0;
            case (in_command)
              CMD_ALLOC: begin
                in_sweep_r <= (total_r == '0 && count_r >= LW'(2));
                swp_i_r    <= count_r - LW'(1);
              end
              CMD_RELEASE: begin
                idx_r      <= midx_in;
                tgt_live_r <= 1'b0;
                if (hit_in) total_r <= total_r + 32'd1;
              end
              CMD_LOOKUP: ;
              default: begin
                reply_r   <= 1'b1;
                ok_r      <= 1'b1;
                rb_i_r    <= '0;
                count_r   <= c_new;
                rb_base_r <= base_handle;
                fhead_r   <= (c_new >= LW'(2)) ? c_new - LW'(1) : NONE;
                ftail_r   <= (c_new >= LW'(2)) ? LW'(1) : NONE;
                lhead_r   <= NONE;
                ltail_r   <= NONE;
                total_r   <= (c_new >= LW'(2)) ? 32'(c_new) - 32'd1 : 32'd0;
              end
            endcase
          end
        end
        S_LOOK: rval_r <= rd_wide[31:0];
        S_PICK: begin
          in_sweep_r <= 1'b0;
          ok_r       <= pick_good;
          rhdl_r     <= pick_good ? pick_id : 16'd0;
          if (pick_good) begin
            idx_r      <= pick_idx;
            tgt_live_r <= 1'b1;
            total_r    <= total_r - 32'd1;
          end
        end
        S_UNL: begin
          if (flg_rdata.linked) begin
            if (prv_rdata == NONE) begin
              if (flg_rdata.live) lhead_r <= nxt_rdata;
              else                fhead_r <= nxt_rdata;
            end
            if (nxt_rdata == NONE) begin
              if (flg_rdata.live) ltail_r <= prv_rdata;
              else                ftail_r <= prv_rdata;
            end
          end
        end
        S_PUSH: begin
          if (hsel == NONE) begin
            if (tgt_live_r) ltail_r <= LW'(idx_r);
            else            ftail_r <= LW'(idx_r);
          end
        end
        S_PUSH2: begin
          if (tgt_live_r) lhead_r <= LW'(idx_r);
          else            fhead_r <= LW'(idx_r);
          if (in_sweep_r) swp_i_r <= swp_i_r - LW'(1);
        end
        S_SWCK: begin
          if (sw_hit) begin
            idx_r      <= sw_idx;
            tgt_live_r <= 1'b0;
            total_r    <= total_r + 32'd1;
          end else begin
            swp_i_r <= swp_i_r - LW'(1);
          end
        end
        S_DONE: reply_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

### rtl/handle_id_allocator_top.sv
`timescale 1ns / 1ps
// Handle table allocator: slots on a live list or a free list, both doubly
// linked by slot index and kept in synchronous-read memories.
// Channels: in_ch takes one command beat (allocate, release, lookup,
// rebuild) with a handle and a value; out_ch gives exactly one result beat
// per command. cfg_we/cfg_idx/cfg_data write base_handle and slots_in_use;
// the user must write them only while the block is idle, as the block does
// not enforce it; slots_in_use takes effect at a rebuild. An allocate that
// finds the free count at zero first sweeps the slots and takes back to the
// free list slots whose stored value is zero; a rebuild writes one slot per
// cycle.
// One command is in flight at a time; each relink reads a slot's links and
// then writes the neighbors, the slot and the list heads over four steps.
// The output register holds a finished result while the next command is
// taken, so a stalled receiver only blocks once a second result is ready.
// Reset clears control state and runs the rebuild pass (in_ch.ready low)
// with base_handle 0 and slots_in_use 256, capped at SLOTS.
module handle_id_allocator_top #(
  parameter int SLOTS      = hia_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = hia_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  hia_in_if.sink                            in_ch,
  hia_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  hia_pkg::cfg_idx_t                 cfg_idx,
  input  logic [hia_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hia_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  logic [15:0]            base_r;
  logic [SLOTS_CFG_W-1:0] slots_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      slots_r <= SLOTS_CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE_HANDLE:  base_r  <= cfg_data;
        CFG_SLOTS_IN_USE: slots_r <= cfg_data[SLOTS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic                  res_valid, res_ready;
  result_t               res;
  logic                  val_we, nxt_we, prv_we, flg_we;
  logic [IW-1:0]         val_waddr, val_raddr, nxt_waddr, prv_waddr, flg_waddr, lnk_raddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic [LW-1:0]         nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;
  link_flag_t            flg_wdata, flg_rdata;

  hia_ctrl #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .IW(IW), .LW(LW)) u_ctrl (
    .clk, .rst_n,
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_command   (in_ch.command),
    .in_handle    (in_ch.item_handle),
    .in_value     (in_ch.item_value),
    .base_handle  (base_r),
    .slots_in_use (slots_r),
    .res_valid, .res_ready, .res,
    .val_we, .val_waddr, .val_wdata, .val_raddr, .val_rdata,
    .nxt_we, .nxt_waddr, .nxt_wdata,
    .prv_we, .prv_waddr, .prv_wdata,
    .flg_we, .flg_waddr, .flg_wdata,
    .lnk_raddr, .nxt_rdata, .prv_rdata, .flg_rdata
  );

  hia_store #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS), .IW(IW), .LW(LW)) u_store (
    .clk,
    .val_we, .val_waddr, .val_wdata, .val_raddr, .val_rdata,
    .nxt_we, .nxt_waddr, .nxt_wdata,
    .prv_we, .prv_waddr, .prv_wdata,
    .flg_we, .flg_waddr, .flg_wdata,
    .lnk_raddr, .nxt_rdata, .prv_rdata, .flg_rdata
  );

  // output register: take a new result when empty or being drained
  logic    out_valid_r;
  result_t out_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_handle = out_r.result_handle;
  assign out_ch.result_value  = out_r.result_value;
  assign out_ch.ok            = out_r.ok;
  assign out_ch.free_left     = out_r.free_left;

endmodule
